// ----- rtl/sync_retry_scheduler_assert.svh -----
// Assertion macros for the checker of the sync retry scheduler.
`ifndef SYNC_RETRY_SCHEDULER_ASSERT_SVH
`define SYNC_RETRY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define SRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// Implication checked at every edge, reset included.
`define SRS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/srs_pkg.sv -----
package srs_pkg;

	// Event kinds, carried on s_tuser.
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_REFUSE = 2'd1,
		OP_REPORT = 2'd2,
		OP_RETRY  = 2'd3
	} op_t;

	// Report classes.
	typedef enum logic [1:0] {
		CLS_GOOD   = 2'd0,
		CLS_PAIRED = 2'd1,
		CLS_REPAIR = 2'd2,
		CLS_RETRY  = 2'd3
	} cls_t;

	// Register indexes (byte address = 4 * index).
	localparam int unsigned REG_IDX_BITS = 3;
	localparam logic [REG_IDX_BITS-1:0] REG_SYNC_ENABLED = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_GAP      = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_SAFETY_INT   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_FAIL_MIN     = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_FAIL_MAX     = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_FIXED_RETRY  = 3'd5;

	localparam int unsigned ADDR_BITS = 5;

	// Register reset values.
	localparam logic [15:0] MIN_GAP_RST      = 16'd60;
	localparam logic [19:0] SAFETY_INT_RST   = 20'd21600;
	localparam logic [15:0] FAIL_MIN_RST     = 16'd60;
	localparam logic [15:0] FAIL_MAX_RST     = 16'd1800;
	localparam logic [15:0] FIXED_RETRY_RST  = 16'd300;

	// Beat widths.
	localparam int unsigned IN_DATA_BITS  = 72;
	localparam int unsigned OUT_DATA_BITS = 88;

endpackage

// ----- rtl/sync_retry_scheduler.sv -----
// Sync retry scheduler: decides when a sync starts and when a failed sync is
// retried, using a capped exponential backoff plus a change trigger. Each
// input beat is one event (tick, refused request, sync report, retry now,
// selected by s_tuser) and produces exactly one result beat with the fire
// flag, the earliest next attempt, the current backoff and the safety
// deadline as they stand after the event. A tick fires when sync is enabled,
// the earliest-attempt time has passed, and either the change stamp is new
// or the safety deadline has passed. Events flow at one per clock while the
// result register drains, via the input stage and then the result register;
// the rate is set by the single state-update pass (one add-and-saturate plus
// compares) on the event in the input stage. A result waiting on m_tready
// stalls that pass and, once the input stage is full, new events. Registers
// sit on an APB-style port at byte address 4 * index; reads return the
// value, pready is always high. Configure only while no events are in flight.
// TIME_BITS sets the width of the internal time arithmetic: input times are
// truncated to it, deadline sums saturate at 2^TIME_BITS - 1, and reported
// times are zero-extended or truncated to 32 bits.
module sync_retry_scheduler #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB-style configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [srs_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// event stream in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [31:0] now_s, [63:32] change_stamp, [65:64] outcome_class, rest zero
	input  logic [srs_pkg::IN_DATA_BITS-1:0]      s_tdata,
	// [1:0] opcode
	input  logic [1:0]                            s_tuser,
	// result stream out
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [0] fire, [32:1] next_attempt_s, [48:33] backoff_s,
	// [80:49] safety_deadline_s, rest zero
	output logic [srs_pkg::OUT_DATA_BITS-1:0]     m_tdata
);

	// ------------------------------------------------------------------
	// Saturating time add: a + b, clamped to the largest time value.
	// ------------------------------------------------------------------
	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] a,
		input logic [TIME_BITS-1:0] b
	);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic        sync_enabled_q;
	logic [15:0] min_gap_q;
	logic [19:0] safety_int_q;
	logic [15:0] fail_min_q;
	logic [15:0] fail_max_q;
	logic [15:0] fixed_retry_q;

	logic                              cfg_wr;
	logic [srs_pkg::REG_IDX_BITS-1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[srs_pkg::ADDR_BITS-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_enabled_q <= 1'b0;
			min_gap_q      <= srs_pkg::MIN_GAP_RST;
			safety_int_q   <= srs_pkg::SAFETY_INT_RST;
			fail_min_q     <= srs_pkg::FAIL_MIN_RST;
			fail_max_q     <= srs_pkg::FAIL_MAX_RST;
			fixed_retry_q  <= srs_pkg::FIXED_RETRY_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				srs_pkg::REG_SYNC_ENABLED: sync_enabled_q <= pwdata[0];
				srs_pkg::REG_MIN_GAP:      min_gap_q      <= pwdata[15:0];
				srs_pkg::REG_SAFETY_INT:   safety_int_q   <= pwdata[19:0];
				srs_pkg::REG_FAIL_MIN:     fail_min_q     <= pwdata[15:0];
				srs_pkg::REG_FAIL_MAX:     fail_max_q     <= pwdata[15:0];
				srs_pkg::REG_FIXED_RETRY:  fixed_retry_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Readback; only word-aligned addresses return a register.
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (cfg_idx)
				srs_pkg::REG_SYNC_ENABLED: prdata = 32'(sync_enabled_q);
				srs_pkg::REG_MIN_GAP:      prdata = 32'(min_gap_q);
				srs_pkg::REG_SAFETY_INT:   prdata = 32'(safety_int_q);
				srs_pkg::REG_FAIL_MIN:     prdata = 32'(fail_min_q);
				srs_pkg::REG_FAIL_MAX:     prdata = 32'(fail_max_q);
				srs_pkg::REG_FIXED_RETRY:  prdata = 32'(fixed_retry_q);
				default:                   prdata = '0;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input stage: hold one event until the update pass takes it.
	// ------------------------------------------------------------------
	logic               valid_s1;
	srs_pkg::op_t       op_s1;
	logic [31:0]        now_s1;
	logic [31:0]        stamp_s1;
	srs_pkg::cls_t      cls_s1;

	logic advance;

	// The update pass runs whenever the result register is free or is
	// being emptied in this same cycle.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= srs_pkg::op_t'(s_tuser);
			now_s1   <= s_tdata[31:0];
			stamp_s1 <= s_tdata[63:32];
			cls_s1   <= srs_pkg::cls_t'(s_tdata[65:64]);
		end
	end

	// ------------------------------------------------------------------
	// Scheduler state
	// ------------------------------------------------------------------
	logic [TIME_BITS-1:0] next_attempt_q, next_attempt_d;
	logic [31:0]          seen_stamp_q, seen_stamp_d;
	logic                 seen_valid_q, seen_valid_d;
	logic [15:0]          backoff_q, backoff_d;
	logic [TIME_BITS-1:0] safety_q, safety_d;
	logic                 claim_pending_q, claim_pending_d;
	logic                 saved_valid_q, saved_valid_d;
	logic [31:0]          saved_stamp_q, saved_stamp_d;
	logic [TIME_BITS-1:0] saved_safety_q, saved_safety_d;
	logic [31:0]          claimed_stamp_q, claimed_stamp_d;
	logic [TIME_BITS-1:0] claimed_safety_q, claimed_safety_d;
	logic                 fire_d;

	logic [TIME_BITS-1:0] now_t;
	logic                 fresh;
	logic                 go;
	logic [16:0]          dbl;
	logic [15:0]          capped;
	logic [TIME_BITS-1:0] tick_safety;

	assign now_t       = TIME_BITS'(now_s1);
	// No stamp seen means any stamp is new.
	assign fresh       = !seen_valid_q || (stamp_s1 != seen_stamp_q);
	assign go          = (now_t >= next_attempt_q) && (fresh || (now_t >= safety_q));
	assign tick_safety = sat_add(now_t, TIME_BITS'(safety_int_q));

	// Double the backoff, restart at the minimum from zero, clamp at the cap.
	assign dbl    = (backoff_q == 16'd0) ? {1'b0, fail_min_q} : {backoff_q, 1'b0};
	assign capped = (dbl > {1'b0, fail_max_q}) ? fail_max_q : dbl[15:0];

	always_comb begin
		next_attempt_d   = next_attempt_q;
		seen_stamp_d     = seen_stamp_q;
		seen_valid_d     = seen_valid_q;
		backoff_d        = backoff_q;
		safety_d         = safety_q;
		claim_pending_d  = claim_pending_q;
		saved_valid_d    = saved_valid_q;
		saved_stamp_d    = saved_stamp_q;
		saved_safety_d   = saved_safety_q;
		claimed_stamp_d  = claimed_stamp_q;
		claimed_safety_d = claimed_safety_q;
		fire_d           = 1'b0;

		case (op_s1)
			srs_pkg::OP_TICK: begin
				// Fire: save what the claim overwrites so a refusal can undo it.
				if (sync_enabled_q && go) begin
					saved_valid_d    = seen_valid_q;
					saved_stamp_d    = seen_stamp_q;
					saved_safety_d   = safety_q;
					seen_stamp_d     = stamp_s1;
					seen_valid_d     = 1'b1;
					next_attempt_d   = sat_add(now_t, TIME_BITS'(min_gap_q));
					safety_d         = tick_safety;
					claimed_stamp_d  = stamp_s1;
					claimed_safety_d = tick_safety;
					claim_pending_d  = 1'b1;
					fire_d           = 1'b1;
				end
			end
			srs_pkg::OP_REFUSE: begin
				// Roll back only the claimed fields nobody touched since.
				if (claim_pending_q) begin
					if (seen_valid_q && (seen_stamp_q == claimed_stamp_q)) begin
						seen_valid_d = saved_valid_q;
						seen_stamp_d = saved_stamp_q;
					end
					if (safety_q == claimed_safety_q) begin
						safety_d = saved_safety_q;
					end
					claim_pending_d = 1'b0;
				end
			end
			srs_pkg::OP_REPORT: begin
				case (cls_s1)
					srs_pkg::CLS_GOOD: begin
						backoff_d = 16'd0;
					end
					srs_pkg::CLS_PAIRED: begin
						backoff_d      = 16'd0;
						next_attempt_d = '0;
						seen_valid_d   = 1'b0;
					end
					srs_pkg::CLS_REPAIR: begin
						backoff_d      = fixed_retry_q;
						next_attempt_d = sat_add(now_t, TIME_BITS'(fixed_retry_q));
						seen_valid_d   = 1'b0;
					end
					default: begin
						backoff_d      = capped;
						next_attempt_d = sat_add(now_t, TIME_BITS'(capped));
						seen_valid_d   = 1'b0;
					end
				endcase
			end
			default: begin
				// Retry now: clear the schedule.
				backoff_d      = 16'd0;
				next_attempt_d = '0;
				seen_valid_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_attempt_q   <= '0;
			seen_stamp_q     <= '0;
			seen_valid_q     <= 1'b1;
			backoff_q        <= '0;
			safety_q         <= '0;
			claim_pending_q  <= 1'b0;
			saved_valid_q    <= 1'b0;
			saved_stamp_q    <= '0;
			saved_safety_q   <= '0;
			claimed_stamp_q  <= '0;
			claimed_safety_q <= '0;
		end else if (advance) begin
			next_attempt_q   <= next_attempt_d;
			seen_stamp_q     <= seen_stamp_d;
			seen_valid_q     <= seen_valid_d;
			backoff_q        <= backoff_d;
			safety_q         <= safety_d;
			claim_pending_q  <= claim_pending_d;
			saved_valid_q    <= saved_valid_d;
			saved_stamp_q    <= saved_stamp_d;
			saved_safety_q   <= saved_safety_d;
			claimed_stamp_q  <= claimed_stamp_d;
			claimed_safety_q <= claimed_safety_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic        fire_q;
	logic [31:0] next_out_q;
	logic [15:0] backoff_out_q;
	logic [31:0] safety_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fire_q        <= fire_d;
			next_out_q    <= 32'(next_attempt_d);
			backoff_out_q <= backoff_d;
			safety_out_q  <= 32'(safety_d);
		end
	end

	assign m_tdata = {7'd0, safety_out_q, backoff_out_q, next_out_q, fire_q};

endmodule

// ----- rtl/srs_checker.sv -----
`include "sync_retry_scheduler_assert.svh"

module srs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [srs_pkg::OUT_DATA_BITS-1:0] m_tdata
);

	// A stalled result beat holds.
	`SRS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// Input side only backs up behind a stalled result.
	`SRS_ASSERT_IMP(a_in_stall, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without output back-pressure")

	// Reset empties the result register.
	`SRS_ASSERT_ALWAYS(a_rst_empty, clk, !arst_n, !m_tvalid, "result valid during reset")

endmodule

bind sync_retry_scheduler srs_checker u_srs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
